### design/iida_pkg.sv
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and codes for the indexed insert/delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

    localparam int POS_BITS   = 8;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 7;

    // request codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_SET    = 2'd3;

    // result codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] item_value;
    } iida_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] read_value;
        logic [COUNT_BITS-1:0] entry_count;
    } iida_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic move;
        logic wr_val;
        logic rd_get;
        logic commit;
    } iida_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mv_pending;
        logic plan_write;
        logic plan_get;
    } iida_sts_t;

endpackage

### design/iida_ctrl.sv
// ----------------------------------------------------------------------------
// iida_ctrl
// Sequencer for one request: decode, shift sweep, final write or read,
// then hand-off into the output register.
// ----------------------------------------------------------------------------
module iida_ctrl import iida_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  iida_sts_t sts,
    output iida_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.mv_pending) begin
                    state_next = S_MOVE;
                end else if (sts.plan_write) begin
                    state_next = S_WRITE;
                end else if (sts.plan_get) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOVE: begin
                // last queued move is written on the edge that leaves this state
                cmd.move = 1'b1;
                if (!sts.mv_pending) begin
                    state_next = sts.plan_write ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                cmd.wr_val = 1'b1;
                state_next = S_DONE;
            end
            S_READ: begin
                cmd.rd_get = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/iida_datapath.sv
// ----------------------------------------------------------------------------
// iida_datapath
// Entry memory, count, request decode and the pipelined shift sweep
// (read one entry, write it to its neighbour in the next cycle).
// ----------------------------------------------------------------------------
module iida_datapath import iida_pkg::*; #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  iida_req_t s_req,
    input  iida_cmd_t cmd,
    output iida_sts_t sts,
    output iida_rsp_t m_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [HANDLE_BITS-1:0] entry_mem [CAPACITY];

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          count_res_reg, count_res_next;
    logic [CW-1:0]          mv_left_reg, mv_left_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          rptr_reg, rptr_next;
    logic [AW-1:0]          wptr_reg, wptr_next;
    logic [AW-1:0]          tgt_reg, tgt_next;
    logic                   dir_down_reg, dir_down_next;
    logic [HANDLE_BITS-1:0] val_reg, val_next;
    logic                   plan_write_reg, plan_write_next;
    logic                   plan_get_reg, plan_get_next;
    logic [1:0]             status_reg, status_next;
    iida_rsp_t              rsp_reg, rsp_next;
    logic [HANDLE_BITS-1:0] mem_q_reg;

    logic                   mem_re, mem_we;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [HANDLE_BITS-1:0] mem_wdata;

    logic [PW-1:0]          pos_w, cnt_w, at_w;
    logic                   pos_ok, full;

    assign pos_w  = PW'(s_req.position);
    assign cnt_w  = PW'(count_reg);
    assign pos_ok = pos_w < cnt_w;
    assign full   = (count_reg == CW'(CAPACITY));
    assign at_w   = pos_ok ? pos_w : cnt_w;

    assign sts.mv_pending = (mv_left_reg != '0);
    assign sts.plan_write = plan_write_reg;
    assign sts.plan_get   = plan_get_reg;
    assign m_rsp          = rsp_reg;

    always_comb begin
        count_next      = count_reg;
        count_res_next  = count_res_reg;
        mv_left_next    = mv_left_reg;
        pend_next       = 1'b0;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        tgt_next        = tgt_reg;
        dir_down_next   = dir_down_reg;
        val_next        = val_reg;
        plan_write_next = plan_write_reg;
        plan_get_next   = plan_get_reg;
        status_next     = status_reg;
        rsp_next        = rsp_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = rptr_reg;
        mem_waddr       = wptr_reg;
        mem_wdata       = mem_q_reg;

        if (cmd.load) begin
            val_next        = HANDLE_BITS'(s_req.item_value);
            plan_write_next = 1'b0;
            plan_get_next   = 1'b0;
            mv_left_next    = '0;
            status_next     = ST_OK;
            count_res_next  = count_reg;
            tgt_next        = AW'(pos_w);
            case (s_req.req_type)
                OP_INSERT: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        plan_write_next = 1'b1;
                        mv_left_next    = CW'(cnt_w - at_w);
                        rptr_next       = AW'(cnt_w - PW'(1));
                        wptr_next       = AW'(cnt_w);
                        tgt_next        = AW'(at_w);
                        dir_down_next   = 1'b1;
                        count_res_next  = count_reg + CW'(1);
                    end
                end
                OP_DELETE: begin
                    if (!pos_ok) begin
                        status_next = ST_BAD_INDEX;
                    end else begin
                        mv_left_next   = CW'(cnt_w - pos_w - PW'(1));
                        rptr_next      = AW'(pos_w + PW'(1));
                        wptr_next      = AW'(pos_w);
                        dir_down_next  = 1'b0;
                        count_res_next = count_reg - CW'(1);
                    end
                end
                OP_GET: begin
                    if (!pos_ok) begin
                        status_next = ST_BAD_INDEX;
                    end else begin
                        plan_get_next = 1'b1;
                    end
                end
                OP_SET: begin
                    if (!pos_ok) begin
                        status_next = ST_BAD_INDEX;
                    end else begin
                        plan_write_next = 1'b1;
                    end
                end
                default: begin
                    status_next = ST_BAD_INDEX;
                end
            endcase
        end

        // sweep: read issued this cycle lands in mem_q_reg, written next cycle
        if (cmd.move && (mv_left_reg != '0)) begin
            mem_re       = 1'b1;
            mem_raddr    = rptr_reg;
            rptr_next    = dir_down_reg ? rptr_reg - AW'(1) : rptr_reg + AW'(1);
            mv_left_next = mv_left_reg - CW'(1);
            pend_next    = 1'b1;
        end
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wptr_reg;
            mem_wdata = mem_q_reg;
            wptr_next = dir_down_reg ? wptr_reg - AW'(1) : wptr_reg + AW'(1);
        end

        if (cmd.wr_val) begin
            mem_we    = 1'b1;
            mem_waddr = tgt_reg;
            mem_wdata = val_reg;
        end
        if (cmd.rd_get) begin
            mem_re    = 1'b1;
            mem_raddr = tgt_reg;
        end

        if (cmd.commit) begin
            count_next           = count_res_reg;
            rsp_next.status      = status_reg;
            rsp_next.read_value  = plan_get_reg ? VALUE_BITS'(mem_q_reg) : '0;
            rsp_next.entry_count = COUNT_BITS'(count_res_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= entry_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            mv_left_reg    <= '0;
            pend_reg       <= 1'b0;
            plan_write_reg <= 1'b0;
            plan_get_reg   <= 1'b0;
        end else begin
            count_reg      <= count_next;
            mv_left_reg    <= mv_left_next;
            pend_reg       <= pend_next;
            plan_write_reg <= plan_write_next;
            plan_get_reg   <= plan_get_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_res_reg <= count_res_next;
        rptr_reg      <= rptr_next;
        wptr_reg      <= wptr_next;
        tgt_reg       <= tgt_next;
        dir_down_reg  <= dir_down_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        rsp_reg       <= rsp_next;
    end

endmodule

### design/indexed_insert_delete_array_top.sv
// One request at a time. A rejected request, or a delete of the last entry, skips the shift and
// the final access; get, set and an append add one access; a delete or an insert that moves
// entries adds the shift sweep, which moves one entry per cycle. s_ready returns on the same
// edge at which the result enters the output register, which may still wait on m_ready.
// Reset (aresetn low, synchronous) empties the array at once; entries are not cleared.
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Ordered handle array with insert, delete, get and set by index.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top import iida_pkg::*; #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  iida_req_t s_req,
    output logic      m_valid,
    input  logic      m_ready,
    output iida_rsp_t m_rsp
);

    iida_cmd_t cmd;
    iida_sts_t sts;

    iida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iida_datapath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .sts     (sts),
        .m_rsp   (m_rsp)
    );

endmodule

### design/iida_checker.sv
// ----------------------------------------------------------------------------
// iida_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module iida_checker import iida_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input iida_rsp_t m_rsp
);

    // a held beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("result beat changed while stalled");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_FULL) |-> (m_rsp.entry_count == COUNT_BITS'(CAPACITY)))
        else $error("full reported below capacity");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((CAPACITY >= 128) || (int'(m_rsp.entry_count) <= CAPACITY)))
        else $error("entry count above capacity");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != ST_OK) |-> (m_rsp.read_value == '0))
        else $error("failed request returned data");

    // an accepted request cannot be answered on the next edge
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind indexed_insert_delete_array_top iida_checker #(.CAPACITY(CAPACITY)) u_iida_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

### dv/indexed_insert_delete_array_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top_tb
// Self-checking bench for the ordered handle array. A short directed run
// covers empty, append, front and middle inserts and bad indexes. A long
// random run then fills, drains and churns the array under bursty input
// and a stalling output. Every result beat is checked against an in-bench
// copy of the array.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top_tb;
    import iida_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1730;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_AT      = 800;   // beats sent before the long output stall
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN, MIX_NOISE} mix_t;

    class handle_array_scoreboard;
        logic [VALUE_BITS-1:0] handles [CAPACITY];
        int unsigned           fill_level;
        iida_rsp_t             predicted_rsp [$];
        int                    errors;
        int                    checked;
        int                    op_seen [4];
        int                    full_seen;
        int                    bad_seen;
        int                    peak_fill;

        function new();
            fill_level = 0;
            errors     = 0;
            checked    = 0;
            full_seen  = 0;
            bad_seen   = 0;
            peak_fill  = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function void note_request(iida_req_t req);
            iida_rsp_t want;
            int        slot;
            want.status     = ST_OK;
            want.read_value = '0;
            op_seen[req.req_type]++;
            if (req.req_type == OP_INSERT) begin
                if (fill_level >= CAPACITY) begin
                    want.status = ST_FULL;
                end else begin
                    // past the end means append
                    slot = (req.position < fill_level) ? int'(req.position) : int'(fill_level);
                    for (int i = int'(fill_level); i > slot; i--) handles[i] = handles[i-1];
                    handles[slot] = req.item_value;
                    fill_level++;
                end
            end else if (req.position >= fill_level) begin
                want.status = ST_BAD_INDEX;
            end else begin
                case (req.req_type)
                    OP_DELETE: begin
                        for (int i = int'(req.position); i + 1 < fill_level; i++)
                            handles[i] = handles[i+1];
                        fill_level--;
                    end
                    OP_GET: want.read_value = handles[req.position];
                    default: handles[req.position] = req.item_value;
                endcase
            end
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_BAD_INDEX) bad_seen++;
            if (fill_level > peak_fill) peak_fill = fill_level;
            want.entry_count = fill_level[COUNT_BITS-1:0];
            predicted_rsp.push_back(want);
        endfunction

        function void check_response(iida_rsp_t got);
            iida_rsp_t want;
            if (predicted_rsp.size() == 0) begin
                $display("%0t ns: unexpected result beat, got %p", $time, got);
                errors++;
                return;
            end
            want = predicted_rsp.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $display("%0t ns: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t ns: read_value mismatch, expected %h, got %h",
                         $time, want.read_value, got.read_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t ns: entry_count mismatch, expected %0d, got %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    iida_req_t s_req   = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    iida_rsp_t m_rsp;

    handle_array_scoreboard board;
    int sent_count  = 0;
    int cycle_count = 0;

    iida_req_t directed [0:20] = '{
        '{OP_GET,    8'd0,   32'h0000_0000},   // empty array: all bad index
        '{OP_DELETE, 8'd0,   32'h0000_0000},
        '{OP_SET,    8'd255, 32'hFFFF_FFFF},
        '{OP_INSERT, 8'd255, 32'hFFFF_FFFF},   // clamped to an append
        '{OP_INSERT, 8'd0,   32'h0000_0000},   // front
        '{OP_INSERT, 8'd1,   32'hA5A5_A5A5},   // middle
        '{OP_INSERT, 8'd200, 32'h5A5A_5A5A},   // append again
        '{OP_GET,    8'd0,   32'h0000_0000},
        '{OP_GET,    8'd1,   32'h1234_5678},
        '{OP_GET,    8'd2,   32'h0000_0000},
        '{OP_GET,    8'd3,   32'h0000_0000},
        '{OP_GET,    8'd4,   32'h0000_0000},   // index equal to count
        '{OP_SET,    8'd3,   32'h8000_0001},
        '{OP_SET,    8'd4,   32'h7FFF_FFFE},
        '{OP_DELETE, 8'd1,   32'h0000_0000},   // middle
        '{OP_DELETE, 8'd2,   32'h0000_0000},   // last
        '{OP_DELETE, 8'd0,   32'h0000_0000},   // front
        '{OP_GET,    8'd0,   32'h0000_0000},
        '{OP_GET,    8'd255, 32'h0000_0000},
        '{OP_DELETE, 8'd0,   32'h0000_0000},   // back to empty
        '{OP_DELETE, 8'd0,   32'h0000_0000}
    };

    indexed_insert_delete_array_top #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (VALUE_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // holds valid and payload until the beat is taken
    task automatic send_request(input iida_req_t req);
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(req);
        sent_count++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // output side: own stall pattern, plus one long hold-off
    initial begin
        int  ready_left;
        bit  ready_phase;
        int  hold_left;
        bit  hold_done;
        ready_left  = 0;
        ready_phase = 1'b1;
        hold_left   = 0;
        hold_done   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) board.check_response(m_rsp);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                if (ready_left == 0) begin
                    if ($urandom_range(3, 0) == 0) begin
                        ready_phase = 1'b1;
                        ready_left  = $urandom_range(200, 50);
                    end else begin
                        ready_phase = !ready_phase;
                        ready_left  = ready_phase ? $urandom_range(12, 1)
                                                  : $urandom_range(5, 1);
                    end
                end
                ready_left--;
                m_ready <= ready_phase;
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: timed out after %0d cycles", $time, cycle_count);
        $display("indexed_insert_delete_array_top regression: fail");
        $finish;
    end

    initial begin
        iida_req_t   req;
        mix_t        mix;
        int          mix_left;
        int          burst_left;
        int          roll;
        int unsigned now_fill;
        board      = new();
        mix        = MIX_FILL;
        mix_left   = 0;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_request(directed[i]);
            pause_sender($urandom_range(3, 0));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix      = mix_t'($urandom_range(3, 0));
                mix_left = $urandom_range(120, 20);
            end
            mix_left--;

            roll = $urandom_range(99, 0);
            case (mix)
                MIX_FILL:  req.req_type = roll < 75 ? OP_INSERT : roll < 85 ? OP_DELETE :
                                          roll < 93 ? OP_GET : OP_SET;
                MIX_DRAIN: req.req_type = roll < 70 ? OP_DELETE : roll < 80 ? OP_INSERT :
                                          roll < 90 ? OP_GET : OP_SET;
                MIX_CHURN: req.req_type = roll < 25 ? OP_INSERT : roll < 50 ? OP_DELETE :
                                          roll < 75 ? OP_GET : OP_SET;
                default:   req.req_type = 2'($urandom);
            endcase

            // mostly live indexes; some at count, past it, or anywhere
            now_fill = board.fill_level;
            roll     = $urandom_range(99, 0);
            if (mix == MIX_NOISE || roll >= 90)
                req.position = 8'($urandom);
            else if (roll < 65 && now_fill > 0)
                req.position = 8'($urandom_range(now_fill - 1, 0));
            else if (roll < 80)
                req.position = now_fill[POS_BITS-1:0];
            else
                req.position = 8'($urandom_range(255, now_fill));

            roll = $urandom_range(19, 0);
            req.item_value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;

            send_request(req);

            if (burst_left > 0) begin
                burst_left--;
            end else begin
                pause_sender($urandom_range(8, 1));
                burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                         : $urandom_range(30, 1);
            end
        end

        s_valid <= 1'b0;
        while (board.predicted_rsp.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);

        $display("Ran %0d requests: %0d insert, %0d delete, %0d get, %0d set; %0d results checked",
                 sent_count, board.op_seen[OP_INSERT], board.op_seen[OP_DELETE],
                 board.op_seen[OP_GET], board.op_seen[OP_SET], board.checked);
        $display("Rejected %0d on a full array and %0d on a bad index; peak count %0d",
                 board.full_seen, board.bad_seen, board.peak_fill);
        if (board.errors == 0) begin
            $display("indexed_insert_delete_array_top regression: pass");
        end else begin
            $display("indexed_insert_delete_array_top regression: fail");
        end
        $finish;
    end

endmodule

### indexed_insert_delete_array_top.f
design/iida_pkg.sv
design/iida_ctrl.sv
design/iida_datapath.sv
design/indexed_insert_delete_array_top.sv
design/iida_checker.sv
dv/indexed_insert_delete_array_top_tb.sv
